// File: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque list.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_REM_HEAD = 3'd2,
        CMD_REM_TAIL = 3'd3,
        CMD_RD_HEAD  = 3'd4,
        CMD_RD_TAIL  = 3'd5,
        CMD_RD_IDX   = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-cycle strobes broadcast to every cell of the chain
    typedef struct packed {
        logic push_head;   // shift toward the tail, new item enters cell 0
        logic pop_head;    // shift toward the head
        logic wr_tail;     // write into the cell just past the tail (index = list size)
        logic bus_load;    // copy each cell's element onto its read bus stage
        logic bus_shift;   // move the read bus one cell toward cell 0
    } t_cell_ctrl;

endpackage

// File: src/bounded_deque_list.sv
// Insert/remove results pass through the pending and then the output register;
// a read at position p (head 0, tail size-1) walks the read bus to cell 0 first.
// One insert/remove item per cycle while the result path does not stall; a read
// holds the input while the element walks the read bus of the cell chain.
// Reset (synchronous, i_rst_n low): list size cleared, result path emptied;
// cell contents stay undefined until written.
// ----------------------------------------------------------------------------
// bounded_deque_list
// Bounded deque with indexed reads, built as a chain of storage cells kept
// in list order; cell 0 holds the head.
// ----------------------------------------------------------------------------
module bounded_deque_list #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bdq_pkg::CMD_W-1:0]           i_cmd,
    input  logic [bdq_pkg::DATA_W-1:0]          i_entry_data,
    input  logic [bdq_pkg::IDX_W-1:0]           i_read_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [bdq_pkg::DATA_W-1:0]          o_read_data,
    output logic [$clog2(CAPACITY+1)-1:0]       o_list_size,
    output logic [bdq_pkg::STATUS_W-1:0]        o_status
);
    import bdq_pkg::*;

    localparam int EW = ELEMENT_WIDTH;
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_cell_ctrl    w_ctrl;
    logic [PW-1:0] w_tail_pos;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_data [CAPACITY];
    logic [EW-1:0] w_bus  [CAPACITY];

    bdq_ctrl #(
        .CAPACITY (CAPACITY),
        .EW       (EW),
        .PW       (PW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_entry_data (i_entry_data),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_list_size  (o_list_size),
        .o_status     (o_status),
        .i_bus_head   (w_bus[0]),
        .o_cell_ctrl  (w_ctrl),
        .o_tail_pos   (w_tail_pos),
        .o_wdata      (w_wdata)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [EW-1:0] w_prev;
        logic [EW-1:0] w_next;
        logic [EW-1:0] w_next_bus;

        // chain ends: new item enters cell 0, the last cell refills from itself
        if (k == 0) begin : g_first
            assign w_prev = w_wdata;
        end else begin : g_mid_prev
            assign w_prev = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_next     = w_data[k];
            assign w_next_bus = '0;
        end else begin : g_mid_next
            assign w_next     = w_data[k+1];
            assign w_next_bus = w_bus[k+1];
        end

        bdq_cell #(
            .EW  (EW),
            .PW  (PW),
            .POS (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_tail_pos  (w_tail_pos),
            .i_wdata     (w_wdata),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .i_next_bus  (w_next_bus),
            .o_data      (w_data[k]),
            .o_bus       (w_bus[k])
        );
    end

endmodule

// File: src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell: holds the element at one list position plus one stage
// of the read bus that carries an element toward the head cell.
// ----------------------------------------------------------------------------
module bdq_cell #(
    parameter int EW  = 32,
    parameter int PW  = 8,
    parameter int POS = 0
) (
    input  logic                 i_clk,
    input  bdq_pkg::t_cell_ctrl  i_ctrl,
    input  logic [PW-1:0]        i_tail_pos,
    input  logic [EW-1:0]        i_wdata,
    input  logic [EW-1:0]        i_prev_data,
    input  logic [EW-1:0]        i_next_data,
    input  logic [EW-1:0]        i_next_bus,
    output logic [EW-1:0]        o_data,
    output logic [EW-1:0]        o_bus
);
    import bdq_pkg::*;

    logic [EW-1:0] r_data;
    logic [EW-1:0] r_bus;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push_head) begin
            r_data <= i_prev_data;
        end else if (i_ctrl.pop_head) begin
            r_data <= i_next_data;
        end else if (i_ctrl.wr_tail && (i_tail_pos == PW'(POS))) begin
            r_data <= i_wdata;
        end

        if (i_ctrl.bus_load) begin
            r_bus <= r_data;
        end else if (i_ctrl.bus_shift) begin
            r_bus <= i_next_bus;
        end
    end

    assign o_data = r_data;
    assign o_bus  = r_bus;

endmodule

// File: src/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Command decode, element count, read scan sequencing and the two-deep
// result path (pending register plus output register).
// ----------------------------------------------------------------------------
module bdq_ctrl #(
    parameter int CAPACITY = 256,
    parameter int EW       = 32,
    parameter int PW       = 8,
    parameter int CW       = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bdq_pkg::CMD_W-1:0]       i_cmd,
    input  logic [bdq_pkg::DATA_W-1:0]      i_entry_data,
    input  logic [bdq_pkg::IDX_W-1:0]       i_read_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bdq_pkg::DATA_W-1:0]      o_read_data,
    output logic [CW-1:0]                   o_list_size,
    output logic [bdq_pkg::STATUS_W-1:0]    o_status,
    input  logic [EW-1:0]                   i_bus_head,
    output bdq_pkg::t_cell_ctrl             o_cell_ctrl,
    output logic [PW-1:0]                   o_tail_pos,
    output logic [EW-1:0]                   o_wdata
);
    import bdq_pkg::*;

    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_hop, n_hop;
    logic          r_pend_v, n_pend_v;
    logic [EW-1:0] r_pend_data, n_pend_data;
    logic [CW-1:0] r_pend_size, n_pend_size;
    t_status       r_pend_st, n_pend_st;
    logic          r_out_v, n_out_v;
    logic [EW-1:0] r_out_data, n_out_data;
    logic [CW-1:0] r_out_size, n_out_size;
    t_status       r_out_st, n_out_st;

    logic       w_accept;
    logic       w_pend_move;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    assign w_pend_move = r_pend_v && (!r_out_v || !i_stall);
    assign o_stall     = (r_state != S_IDLE) || (r_pend_v && !w_pend_move);
    assign w_accept    = i_valid && !o_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hop       = r_hop;
        n_pend_v    = r_pend_v && !w_pend_move;
        n_pend_data = r_pend_data;
        n_pend_size = r_pend_size;
        n_pend_st   = r_pend_st;
        w_ctrl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pend_v    = 1'b1;
                    n_pend_data = '0;
                    n_pend_st   = ST_OK;
                    case (i_cmd)
                        CMD_INS_HEAD: begin
                            if (w_full) begin
                                n_pend_st = ST_FULL;
                            end else begin
                                w_ctrl.push_head = 1'b1;
                                n_count          = r_count + CW'(1);
                            end
                        end
                        CMD_INS_TAIL: begin
                            if (w_full) begin
                                n_pend_st = ST_FULL;
                            end else begin
                                w_ctrl.wr_tail = 1'b1;
                                n_count        = r_count + CW'(1);
                            end
                        end
                        CMD_REM_HEAD: begin
                            if (w_empty) begin
                                n_pend_st = ST_EMPTY;
                            end else begin
                                w_ctrl.pop_head = 1'b1;
                                n_count         = r_count - CW'(1);
                            end
                        end
                        CMD_REM_TAIL: begin
                            if (w_empty) begin
                                n_pend_st = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_RD_HEAD, CMD_RD_TAIL, CMD_RD_IDX: begin
                            if (w_empty) begin
                                n_pend_st = ST_EMPTY;
                            end else if ((i_cmd == CMD_RD_IDX) &&
                                         (CMP_W'(i_read_index) >= CMP_W'(r_count))) begin
                                n_pend_st = ST_RANGE;
                            end else begin
                                // valid read: scan the bus, result comes later
                                n_pend_v        = 1'b0;
                                w_ctrl.bus_load = 1'b1;
                                n_state         = S_SCAN;
                                if (i_cmd == CMD_RD_HEAD) begin
                                    n_hop = '0;
                                end else if (i_cmd == CMD_RD_TAIL) begin
                                    n_hop = PW'(r_count - CW'(1));
                                end else begin
                                    n_hop = PW'(i_read_index);
                                end
                            end
                        end
                        default: ;
                    endcase
                    n_pend_size = n_count;
                end
            end
            S_SCAN: begin
                if (r_hop == '0) begin
                    n_pend_v    = 1'b1;
                    n_pend_data = i_bus_head;
                    n_pend_size = r_count;
                    n_pend_st   = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    w_ctrl.bus_shift = 1'b1;
                    n_hop            = r_hop - PW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_v    = r_out_v && i_stall;
        n_out_data = r_out_data;
        n_out_size = r_out_size;
        n_out_st   = r_out_st;
        if (w_pend_move) begin
            n_out_v    = 1'b1;
            n_out_data = r_pend_data;
            n_out_size = r_pend_size;
            n_out_st   = r_pend_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hop       <= n_hop;
            r_pend_v    <= n_pend_v;
            r_pend_data <= n_pend_data;
            r_pend_size <= n_pend_size;
            r_pend_st   <= n_pend_st;
            r_out_v     <= n_out_v;
            r_out_data  <= n_out_data;
            r_out_size  <= n_out_size;
            r_out_st    <= n_out_st;
        end
    end

    assign o_valid     = r_out_v;
    assign o_read_data = DATA_W'(r_out_data);
    assign o_list_size = r_out_size;
    assign o_status    = r_out_st;
    assign o_cell_ctrl = w_ctrl;
    assign o_tail_pos  = PW'(r_count);
    assign o_wdata     = EW'(i_entry_data);

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_deque_list: a directed opening (empty and
// boundary cases), then random command streams that keep the list small, fill
// it to capacity and work near the top. A ring-buffer predictor computes each
// result, and the monitor checks every result against it in order.
// ----------------------------------------------------------------------------
module tb;
    import bdq_pkg::*;

    localparam int DEPTH       = 256;
    localparam int SIZE_W      = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT  = 4000;   // well above the longest read scan
    localparam int TAIL_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  idx;
    } t_deque_op;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [SIZE_W-1:0] list_size;
        t_status           status;
    } t_deque_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [DATA_W-1:0]   i_entry_data = '0;
    logic [IDX_W-1:0]    i_read_index = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DATA_W-1:0]   o_read_data;
    logic [SIZE_W-1:0]   o_list_size;
    logic [STATUS_W-1:0] o_status;

    bounded_deque_list #(
        .CAPACITY      (DEPTH),
        .ELEMENT_WIDTH (32)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_entry_data (i_entry_data),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_list_size  (o_list_size),
        .o_status     (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_deque_op     op_queue[$];
    t_deque_result expect_q[$];

    // predictor state
    logic [DATA_W-1:0] model_store [DEPTH];
    int unsigned       model_head = 0;
    int unsigned       model_count = 0;

    int  gen_count = 0;
    int  total_ops = 0;
    int  ops_taken = 0;
    int  results_checked = 0;
    int  err_count = 0;
    int  full_hits = 0, empty_hits = 0, range_hits = 0, good_reads = 0;
    int  peak_size = 0;
    int  idle_cycles = 0;
    int  gap_left = 0, burst_left = 0;
    int  stall_mode = 0, stall_left = 0, stall_phase = 0;
    bit  run_started = 1'b0;
    bit  tail_wait = 1'b0;
    bit  item_taken = 1'b0;

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        err_count++;
        $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_checked, field, got, want);
    endtask

    task automatic predict_deque(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] d,
                                 input logic [IDX_W-1:0] x);
        t_deque_result r;
        r.read_data = '0;
        r.status    = ST_OK;
        case (c)
            CMD_INS_HEAD: begin
                if (model_count >= DEPTH) r.status = ST_FULL;
                else begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    model_store[model_head] = d;
                    model_count++;
                end
            end
            CMD_INS_TAIL: begin
                if (model_count >= DEPTH) r.status = ST_FULL;
                else begin
                    model_store[(model_head + model_count) % DEPTH] = d;
                    model_count++;
                end
            end
            CMD_REM_HEAD: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else begin
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            CMD_REM_TAIL: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else model_count--;
            end
            CMD_RD_HEAD: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else r.read_data = model_store[model_head];
            end
            CMD_RD_TAIL: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else r.read_data = model_store[(model_head + model_count - 1) % DEPTH];
            end
            CMD_RD_IDX: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else if (x >= model_count) r.status = ST_RANGE;
                else r.read_data = model_store[(model_head + x) % DEPTH];
            end
            default: ;
        endcase
        r.list_size = SIZE_W'(model_count);
        case (r.status)
            ST_FULL:  full_hits++;
            ST_EMPTY: empty_hits++;
            ST_RANGE: range_hits++;
            default:  if (c inside {CMD_RD_HEAD, CMD_RD_TAIL, CMD_RD_IDX}) good_reads++;
        endcase
        if (model_count > peak_size) peak_size = model_count;
        expect_q.push_back(r);
    endtask

    // stimulus generation keeps its own size count to steer the list
    task automatic queue_op(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] d,
                            input logic [IDX_W-1:0] x);
        t_deque_op op;
        op.cmd  = c;
        op.data = d;
        op.idx  = x;
        op_queue.push_back(op);
        case (c)
            CMD_INS_HEAD, CMD_INS_TAIL: if (gen_count < DEPTH) gen_count++;
            CMD_REM_HEAD, CMD_REM_TAIL: if (gen_count > 0) gen_count--;
            default: ;
        endcase
    endtask

    task automatic random_op(input int target);
        int               r;
        logic [CMD_W-1:0] c;
        logic [IDX_W-1:0] x;
        r = $urandom_range(0, 99);
        x = IDX_W'($urandom_range(0, 255));
        if (r < 6) begin
            c = CMD_W'($urandom_range(0, 7));
        end else if (r < 35) begin
            c = CMD_W'($urandom_range(CMD_RD_HEAD, CMD_RD_IDX));
            if (gen_count > 0 && $urandom_range(0, 9) < 8)
                x = IDX_W'($urandom_range(0, gen_count - 1));
        end else if (gen_count < target) begin
            c = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
        end else if (gen_count > target) begin
            c = $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
        end else begin
            c = CMD_W'($urandom_range(CMD_INS_HEAD, CMD_REM_TAIL));
        end
        queue_op(c, $urandom, x);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        item_taken <= i_valid && !o_stall;
        if (i_valid && !o_stall) begin
            predict_deque(i_cmd, i_entry_data, i_read_index);
            ops_taken++;
        end
    end

    always @(negedge i_clk) begin : drive
        t_deque_op op;
        if (run_started && (!i_valid || item_taken)) begin
            if (gap_left > 0 || op_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                op = op_queue.pop_front();
                i_cmd        <= op.cmd;
                i_entry_data <= op.data;
                i_read_index <= op.idx;
                i_valid      <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // result-side backpressure: modes of none, light, heavy and periodic stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 7;
        case (stall_mode)
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 9) < 7);
            3:       i_stall <= (stall_phase < 3);
            default: i_stall <= 1'b0;
        endcase
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : monitor
        t_deque_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_checked++;
            if (expect_q.size() == 0) begin
                report_mismatch("result with nothing pending, read_data", o_read_data, '0);
            end else begin
                want = expect_q.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_list_size !== want.list_size)
                    report_mismatch("list_size", DATA_W'(o_list_size),
                                    DATA_W'(want.list_size));
                if (o_status !== want.status)
                    report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (run_started && !tail_wait) begin
            if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("** bounded_deque_list: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        // empty list corner cases
        queue_op(CMD_REM_HEAD, 32'hFFFF_FFFF, 8'hFF);
        queue_op(CMD_REM_TAIL, 32'h0, 8'h0);
        queue_op(CMD_RD_HEAD, 32'h0, 8'h0);
        queue_op(CMD_RD_TAIL, 32'h0, 8'h0);
        queue_op(CMD_RD_IDX, 32'h0, 8'h0);
        queue_op(CMD_UNUSED, 32'h0, 8'h0);
        // both ends, extreme words
        queue_op(CMD_INS_TAIL, 32'hFFFF_FFFF, 8'h0);
        queue_op(CMD_INS_HEAD, 32'h0000_0000, 8'hFF);
        queue_op(CMD_INS_TAIL, 32'hA5A5_A5A5, 8'h0);
        queue_op(CMD_INS_HEAD, 32'h5A5A_5A5A, 8'h0);
        queue_op(CMD_RD_HEAD, 32'h0, 8'h0);
        queue_op(CMD_RD_TAIL, 32'h0, 8'h0);
        queue_op(CMD_RD_IDX, 32'h0, 8'd0);
        queue_op(CMD_RD_IDX, 32'h0, 8'd3);
        queue_op(CMD_RD_IDX, 32'h0, 8'd4);   // one past the tail
        queue_op(CMD_RD_IDX, 32'h0, 8'hFF);
        queue_op(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        queue_op(CMD_REM_HEAD, 32'h0, 8'h0);
        queue_op(CMD_REM_TAIL, 32'h0, 8'h0);
        queue_op(CMD_RD_IDX, 32'h0, 8'd1);
        queue_op(CMD_REM_HEAD, 32'h0, 8'h0);
        queue_op(CMD_REM_TAIL, 32'h0, 8'h0);
        queue_op(CMD_RD_IDX, 32'h0, 8'd0);

        // small list churn
        while (op_queue.size() < 125) begin : small_churn
            int target;
            target = $urandom_range(0, 12);
            repeat ($urandom_range(8, 24)) random_op(target);
        end
        // fill to capacity, then lean on the full list
        while (gen_count < DEPTH) random_op(DEPTH);
        repeat (20) random_op(DEPTH);
        // work near the top
        while (op_queue.size() < 560) begin : near_full
            int target;
            target = $urandom_range(224, DEPTH);
            repeat ($urandom_range(6, 16)) random_op(target);
        end
        total_ops = op_queue.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n     <= 1'b1;
        run_started <= 1'b1;

        while (ops_taken < total_ops || expect_q.size() != 0) @(posedge i_clk);
        tail_wait = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d commands driven, %0d results checked, peak list size %0d",
                 total_ops, results_checked, peak_size);
        $display("%0d good reads, %0d full inserts, %0d empty cases, %0d out-of-range reads",
                 good_reads, full_hits, empty_hits, range_hits);
        if (err_count == 0) begin
            $display("** bounded_deque_list: PASSED **");
        end else begin
            $display("** bounded_deque_list: FAILED **");
        end
        $finish;
    end

endmodule
